/* hdl/xep_pkg.sv */
// Package for the xorshift entropy pool: transaction types, pool type,
// datapath operation codes and seeding constants. Depends on nothing.
package xep_pkg;

  localparam int unsigned MAX_REQUEST_BYTES_DEF = 256;
  localparam int unsigned LENGTH_W = 9;

  localparam logic [31:0] SEED_K0 = 32'hD0B00001;
  localparam logic [31:0] SEED_K1 = 32'h9E3779B9;
  localparam logic [31:0] SEED_K2 = 32'h85EBCA6B;
  localparam logic [31:0] SEED_K3 = 32'hC2B2AE35;

  localparam logic [1:0] MODE_SEED    = 2'd0;
  localparam logic [1:0] MODE_MIX     = 2'd1;
  localparam logic [1:0] MODE_REQUEST = 2'd2;

  localparam logic [1:0] OP_SEED = 2'd0;
  localparam logic [1:0] OP_MIX  = 2'd1;
  localparam logic [1:0] OP_STEP = 2'd2;

  typedef logic [3:0][31:0] pool_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [63:0]         sample;
    logic [63:0]         second_stamp;
    logic [LENGTH_W-1:0] length;
  } req_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  byte_count;
    logic        last;
  } rsp_t;

  // Control from the sequencer to the shared datapath.
  typedef struct packed {
    logic [1:0] op;
    logic [1:0] sel;
    logic [4:0] rot;
  } unit_ctrl_t;

endpackage

/* hdl/xorshift_entropy_pool_core.sv */
// Xorshift entropy pool core: top level with sequencer and output register.
// Seed and mix each update the pool once after the transaction is accepted;
// a request takes one mix step and then one generator word per cycle while the
// output is not stalled, ceil(length/4) words of the saturated length, paced by the shared datapath.
// Mode 3 is dropped at acceptance. Reset (rst, synchronous) clears the pool,
// the mix counter and all handshake state. Depends on xep_pkg and xep_unit.
module xorshift_entropy_pool_core #(
  parameter int unsigned MAX_REQUEST_BYTES = xep_pkg::MAX_REQUEST_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  xep_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output xep_pkg::rsp_t rsp
);

  localparam int unsigned LW = xep_pkg::LENGTH_W;
  // The length field cannot exceed its own range, so saturation stops there.
  localparam int unsigned SAT_BYTES =
    (MAX_REQUEST_BYTES < ((1 << LW) - 1)) ? MAX_REQUEST_BYTES : ((1 << LW) - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEED = 2'd1;
  localparam logic [1:0] ST_MIX  = 2'd2;
  localparam logic [1:0] ST_GEN  = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic          gen_after;
  logic [31:0]   opa;
  logic [31:0]   opb;
  logic [31:0]   opc;
  logic [LW-1:0] remaining;
  logic [LW-1:0] eff_len;
  xep_pkg::pool_t pool;
  xep_pkg::pool_t pool_next;
  logic [31:0]   word;
  logic [31:0]   mix_count;
  logic [4:0]    mix_mod;      // mix_count modulo 31, kept alongside the counter
  logic [4:0]    mix_mod_next;
  xep_pkg::unit_ctrl_t ctrl;
  logic          req_take;
  logic          slot_free;
  logic          gen_fire;

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign gen_fire  = (state == ST_GEN) && slot_free;

  assign eff_len = (req.length > LW'(SAT_BYTES)) ? LW'(SAT_BYTES) : req.length;

  // Modulo 31 of the incremented counter. The counter wraps from all ones,
  // whose residue is 3, to zero, so the wrap resets the residue explicitly.
  always_comb begin
    if (mix_count == '1 || mix_mod == 5'd30) begin
      mix_mod_next = 5'd0;
    end else begin
      mix_mod_next = mix_mod + 5'd1;
    end
  end

  always_comb begin
    ctrl.sel = mix_count[1:0];
    ctrl.rot = mix_mod_next + 5'd1;
    case (state)
      ST_SEED: ctrl.op = xep_pkg::OP_SEED;
      ST_MIX:  ctrl.op = xep_pkg::OP_MIX;
      default: ctrl.op = xep_pkg::OP_STEP;
    endcase
  end

  xep_unit u_unit (
    .ctrl      (ctrl),
    .pool      (pool),
    .opa       (opa),
    .opb       (opb),
    .opc       (opc),
    .pool_next (pool_next),
    .word      (word)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_take) begin
          case (req.mode)
            xep_pkg::MODE_SEED:    state_next = ST_SEED;
            xep_pkg::MODE_MIX:     state_next = ST_MIX;
            xep_pkg::MODE_REQUEST: state_next = ST_MIX;
            default:               state_next = ST_IDLE;
          endcase
        end
      end
      ST_SEED: state_next = ST_IDLE;
      ST_MIX: begin
        state_next = (gen_after && remaining != '0) ? ST_GEN : ST_IDLE;
      end
      ST_GEN: begin
        if (gen_fire && remaining <= LW'(4)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pool      <= '0;
      mix_count <= '0;
      mix_mod   <= '0;
      rsp_valid <= 1'b0;
      gen_after <= 1'b0;
      remaining <= '0;
    end else begin
      state <= state_next;
      if (req_take) begin
        gen_after <= (req.mode == xep_pkg::MODE_REQUEST);
        remaining <= eff_len;
      end
      if (state == ST_SEED) begin
        pool <= pool_next;
      end
      if (state == ST_MIX) begin
        pool      <= pool_next;
        mix_count <= mix_count + 32'd1;
        mix_mod   <= mix_mod_next;
      end
      if (gen_fire) begin
        pool      <= pool_next;
        remaining <= (remaining <= LW'(4)) ? '0 : remaining - LW'(4);
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Operand and result payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (req_take) begin
      opa <= req.sample[31:0];
      opb <= req.sample[63:32];
      opc <= req.second_stamp[42:11];
    end
    if (gen_fire) begin
      rsp.word       <= word;
      rsp.byte_count <= (remaining >= LW'(4)) ? 3'd4 : remaining[2:0];
      rsp.last       <= (remaining <= LW'(4));
    end
  end

endmodule

/* hdl/xep_unit.sv */
// Shared pool datapath: seeding, rotated sample mix and xorshift128 step,
// with the all-zero guard. Depends on xep_pkg.
module xep_unit (
  input  xep_pkg::unit_ctrl_t ctrl,
  input  xep_pkg::pool_t      pool,
  input  logic [31:0]         opa,
  input  logic [31:0]         opb,
  input  logic [31:0]         opc,
  output xep_pkg::pool_t      pool_next,
  output logic [31:0]         word
);

  logic [63:0] rot_wide;
  logic [31:0] rotated;
  logic [31:0] t;
  logic [31:0] s;
  xep_pkg::pool_t pool_calc;

  assign rot_wide = {opa, opa} << ctrl.rot;
  assign rotated  = rot_wide[63:32];

  assign t    = pool[3] ^ (pool[3] << 11);
  assign s    = t ^ (t >> 8);
  assign word = s ^ pool[0] ^ (pool[0] >> 19);

  always_comb begin
    pool_calc = pool;
    case (ctrl.op)
      xep_pkg::OP_SEED: begin
        pool_calc[0] = opa ^ xep_pkg::SEED_K0;
        pool_calc[1] = opb ^ xep_pkg::SEED_K1;
        pool_calc[2] = opc ^ xep_pkg::SEED_K2;
        pool_calc[3] = xep_pkg::SEED_K3;
      end
      xep_pkg::OP_MIX: begin
        pool_calc[ctrl.sel] = pool[ctrl.sel] ^ rotated;
      end
      xep_pkg::OP_STEP: begin
        pool_calc[0] = word;
        pool_calc[1] = pool[0];
        pool_calc[2] = pool[1];
        pool_calc[3] = pool[2];
      end
      default: begin
        pool_calc = pool;
      end
    endcase
  end

  // An xorshift step never reaches zero from a non-zero pool, so the guard
  // only matters after seeding or mixing.
  always_comb begin
    pool_next = pool_calc;
    if (ctrl.op != xep_pkg::OP_STEP && pool_calc == '0) begin
      pool_next[0] = 32'd1;
    end
  end

endmodule
